// File: rtl/cfpt_pkg.sv
`default_nettype none
// Shared types and constants for the cube-free position table.
// Holds the sequencer control word, the condition and step codes, and the microcode table.
// No dependencies.
package cfpt_pkg;

	// Result status codes.
	localparam logic [1:0] ST_FREE     = 2'd0;
	localparam logic [1:0] ST_NOT_FREE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_BUILT    = 2'd3;

	// Root counter and product widths. The limit never exceeds 16 bits, so the root
	// stops at 41 and its cube stays below 2**17.
	localparam int unsigned K_W    = 6;
	localparam int unsigned KK_W   = 12;
	localparam int unsigned CUBE_W = 18;

	// Microcode step addresses.
	localparam int unsigned UPC_W = 4;
	localparam logic [UPC_W-1:0] UP_IDLE  = 4'd0;
	localparam logic [UPC_W-1:0] UP_DISP  = 4'd1;
	localparam logic [UPC_W-1:0] UP_FILL  = 4'd2;
	localparam logic [UPC_W-1:0] UP_KINC  = 4'd3;
	localparam logic [UPC_W-1:0] UP_KSQ   = 4'd4;
	localparam logic [UPC_W-1:0] UP_KCUBE = 4'd5;
	localparam logic [UPC_W-1:0] UP_KCHK  = 4'd6;
	localparam logic [UPC_W-1:0] UP_MARK  = 4'd7;
	localparam logic [UPC_W-1:0] UP_RSET  = 4'd8;
	localparam logic [UPC_W-1:0] UP_RRD   = 4'd9;
	localparam logic [UPC_W-1:0] UP_RUPD  = 4'd10;
	localparam logic [UPC_W-1:0] UP_QRES  = 4'd11;
	localparam logic [UPC_W-1:0] UP_BDONE = 4'd12;

	// Jump conditions.
	localparam logic [2:0] CND_NEVER    = 3'd0;
	localparam logic [2:0] CND_NO_IN    = 3'd1;
	localparam logic [2:0] CND_QUERY    = 3'd2;
	localparam logic [2:0] CND_PTR_GT   = 3'd3;
	localparam logic [2:0] CND_CUBE_GT  = 3'd4;
	localparam logic [2:0] CND_OUT_BUSY = 3'd5;

	// Pointer operations.
	localparam logic [2:0] PTR_HOLD = 3'd0;
	localparam logic [2:0] PTR_ONE  = 3'd1;
	localparam logic [2:0] PTR_INC  = 3'd2;
	localparam logic [2:0] PTR_CUBE = 3'd3;
	localparam logic [2:0] PTR_ADD  = 3'd4;

	// Root counter operations.
	localparam logic [1:0] K_HOLD = 2'd0;
	localparam logic [1:0] K_ONE  = 2'd1;
	localparam logic [1:0] K_INC  = 2'd2;

	// Memory write data select.
	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_ONE  = 2'd1;
	localparam logic [1:0] WR_ZERO = 2'd2;
	localparam logic [1:0] WR_CNT  = 2'd3;

	// Memory read address select.
	localparam logic [1:0] RD_NONE  = 2'd0;
	localparam logic [1:0] RD_QUERY = 2'd1;
	localparam logic [1:0] RD_PTR   = 2'd2;

	// Running count operations.
	localparam logic [1:0] CNT_HOLD   = 2'd0;
	localparam logic [1:0] CNT_CLR    = 2'd1;
	localparam logic [1:0] CNT_INC_NZ = 2'd2;

	// Result register loads.
	localparam logic [1:0] OUT_NONE  = 2'd0;
	localparam logic [1:0] OUT_QUERY = 2'd1;
	localparam logic [1:0] OUT_BUILT = 2'd2;

	typedef struct packed {
		logic             in_rdy;
		logic             latch;
		logic [2:0]       ptr_op;
		logic [1:0]       k_op;
		logic             kk_en;
		logic             cube_en;
		logic [1:0]       wr_sel;
		logic [1:0]       rd_sel;
		logic [1:0]       cnt_op;
		logic [1:0]       out_op;
		logic [2:0]       cond;
		logic [UPC_W-1:0] jmp;
		logic [UPC_W-1:0] nxt;
	} ctrl_t;

	typedef struct packed {
		logic no_in;
		logic is_query;
		logic ptr_gt;
		logic cube_gt;
		logic out_busy;
	} flags_t;

	// Microcode table: one control word per step. When the condition holds the step
	// goes to jmp, otherwise to nxt. Datapath actions fire every cycle the step runs.
	function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
		ctrl_t w;
		w = '0;
		w.nxt = UP_IDLE;
		w.jmp = UP_IDLE;
		unique case (addr)
			UP_IDLE: begin
				w.in_rdy = 1'b1;
				w.latch  = 1'b1;
				w.cond   = CND_NO_IN;
				w.jmp    = UP_IDLE;
				w.nxt    = UP_DISP;
			end
			UP_DISP: begin
				w.rd_sel = RD_QUERY;
				w.ptr_op = PTR_ONE;
				w.k_op   = K_ONE;
				w.cond   = CND_QUERY;
				w.jmp    = UP_QRES;
				w.nxt    = UP_FILL;
			end
			UP_FILL: begin
				w.wr_sel = WR_ONE;
				w.ptr_op = PTR_INC;
				w.cond   = CND_PTR_GT;
				w.jmp    = UP_KINC;
				w.nxt    = UP_FILL;
			end
			UP_KINC: begin
				w.k_op = K_INC;
				w.nxt  = UP_KSQ;
			end
			UP_KSQ: begin
				w.kk_en = 1'b1;
				w.nxt   = UP_KCUBE;
			end
			UP_KCUBE: begin
				w.cube_en = 1'b1;
				w.nxt     = UP_KCHK;
			end
			UP_KCHK: begin
				w.ptr_op = PTR_CUBE;
				w.cond   = CND_CUBE_GT;
				w.jmp    = UP_RSET;
				w.nxt    = UP_MARK;
			end
			UP_MARK: begin
				w.wr_sel = WR_ZERO;
				w.ptr_op = PTR_ADD;
				w.cond   = CND_PTR_GT;
				w.jmp    = UP_KINC;
				w.nxt    = UP_MARK;
			end
			UP_RSET: begin
				w.ptr_op = PTR_ONE;
				w.cnt_op = CNT_CLR;
				w.nxt    = UP_RRD;
			end
			UP_RRD: begin
				w.rd_sel = RD_PTR;
				w.cond   = CND_PTR_GT;
				w.jmp    = UP_BDONE;
				w.nxt    = UP_RUPD;
			end
			UP_RUPD: begin
				w.wr_sel = WR_CNT;
				w.cnt_op = CNT_INC_NZ;
				w.ptr_op = PTR_INC;
				w.nxt    = UP_RRD;
			end
			UP_QRES: begin
				w.out_op = OUT_QUERY;
				w.cond   = CND_OUT_BUSY;
				w.jmp    = UP_QRES;
				w.nxt    = UP_IDLE;
			end
			UP_BDONE: begin
				w.out_op = OUT_BUILT;
				w.cond   = CND_OUT_BUSY;
				w.jmp    = UP_BDONE;
				w.nxt    = UP_IDLE;
			end
			default: begin
				w.nxt = UP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/cfpt_seq.sv
`default_nettype none
// Microcode sequencer for the cube-free position table: step counter, condition
// select and control word lookup. Depends on cfpt_pkg.
module cfpt_seq
	import cfpt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output ctrl_t       ctrl
);

	logic [UPC_W-1:0] upc_q;
	logic             take;

	assign ctrl = ucode(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			CND_NEVER:    take = 1'b0;
			CND_NO_IN:    take = flags.no_in;
			CND_QUERY:    take = flags.is_query;
			CND_PTR_GT:   take = flags.ptr_gt;
			CND_CUBE_GT:  take = flags.cube_gt;
			CND_OUT_BUSY: take = flags.out_busy;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UP_IDLE;
		end else begin
			upc_q <= take ? ctrl.jmp : ctrl.nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/cube_free_position_table.sv
`default_nettype none
// Top level of the cube-free position table: rank memory, datapath and result register.
// Depends on cfpt_pkg and cfpt_seq.
//
//  Channel   Handshake                  Payload
//  input     in_valid / in_ready        operation, query_value
//  output    out_valid / out_ready      status, rank
//  config    cfg_we                     cfg_wdata (table_limit)
//
// A query beat runs through accept, a registered rank memory read and the result load.
// A build beat (lim taken at accept) fills 1..lim, runs each cube root through increment,
// square, cube and check, zeroes its multiples, then ranks each entry by read and update.
// Reset clears the control state and the built flag; the rank memory is not cleared,
// since a query is only ever answered from entries that the last build wrote.
// While a result waits in the output register, the next item holds in its final step.
module cube_free_position_table
	import cfpt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [15:0] query_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      rank
);

	localparam int unsigned AW      = $clog2(TABLE_DEPTH);
	localparam int unsigned PW      = AW + 1;
	localparam int unsigned LIM_MAX = TABLE_DEPTH - 1;

	ctrl_t  ctrl;
	flags_t flags;

	// Configuration and latched item.
	logic [15:0]     table_limit_q;
	logic            op_q;
	logic [15:0]     qv_q;
	logic [AW-1:0]   lim_q;
	logic [AW-1:0]   lim_d;

	// Datapath registers.
	logic [PW-1:0]     ptr_q;
	logic [K_W-1:0]    k_q;
	logic [KK_W-1:0]   kk_q;
	logic [CUBE_W-1:0] cube_q;
	logic [15:0]       cnt_q;
	logic [15:0]       cnt_inc;

	// Build status.
	logic            ready_q;
	logic [AW-1:0]   built_q;

	// Rank memory.
	logic [15:0]     mem_q [TABLE_DEPTH];
	logic [15:0]     rd_q;
	logic [AW-1:0]   rd_addr;
	logic            rd_en;
	logic            wr_en;
	logic [15:0]     wr_data;

	// Result register.
	logic            ovalid_q;
	logic [1:0]      status_q;
	logic [15:0]     rank_q;
	logic            out_busy;
	logic            out_load;
	logic            accept;
	logic            q_range;

	cfpt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign in_ready  = ctrl.in_rdy;
	assign accept    = in_valid & ctrl.in_rdy;
	assign out_valid = ovalid_q;
	assign status    = status_q;
	assign rank      = rank_q;
	assign out_busy  = ovalid_q & ~out_ready;
	assign out_load  = (ctrl.out_op != OUT_NONE) & ~out_busy;
	assign cnt_inc   = cnt_q + 16'd1;

	assign flags.no_in    = ~in_valid;
	assign flags.is_query = op_q;
	assign flags.ptr_gt   = ptr_q > {1'b0, lim_q};
	assign flags.cube_gt  = 32'(cube_q) > 32'(lim_q);
	assign flags.out_busy = out_busy;

	// The limit saturates at the last entry of the memory.
	always_comb begin
		if (32'(table_limit_q) > LIM_MAX) begin
			lim_d = AW'(LIM_MAX);
		end else begin
			lim_d = AW'(table_limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			table_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch && accept) begin
			op_q  <= operation;
			qv_q  <= query_value;
			lim_q <= lim_d;
		end
	end

	// Pointer, cube root and running count.
	always_ff @(posedge clk) begin
		unique case (ctrl.ptr_op)
			PTR_HOLD: ptr_q <= ptr_q;
			PTR_ONE:  ptr_q <= PW'(1);
			PTR_INC:  ptr_q <= ptr_q + PW'(1);
			PTR_CUBE: ptr_q <= PW'(cube_q);
			PTR_ADD:  ptr_q <= ptr_q + PW'(cube_q);
			default:  ptr_q <= ptr_q;
		endcase
		unique case (ctrl.k_op)
			K_HOLD:  k_q <= k_q;
			K_ONE:   k_q <= K_W'(1);
			K_INC:   k_q <= k_q + K_W'(1);
			default: k_q <= k_q;
		endcase
		if (ctrl.kk_en) begin
			kk_q <= KK_W'(k_q) * KK_W'(k_q);
		end
		if (ctrl.cube_en) begin
			cube_q <= CUBE_W'(kk_q) * CUBE_W'(k_q);
		end
		unique case (ctrl.cnt_op)
			CNT_HOLD:   cnt_q <= cnt_q;
			CNT_CLR:    cnt_q <= 16'd0;
			CNT_INC_NZ: cnt_q <= (rd_q != 16'd0) ? cnt_inc : cnt_q;
			default:    cnt_q <= cnt_q;
		endcase
	end

	// Writes only land inside 1..lim; a ranking step writes only cube-free entries.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = 16'd0;
		unique case (ctrl.wr_sel)
			WR_NONE: wr_en = 1'b0;
			WR_ONE: begin
				wr_en   = ~flags.ptr_gt;
				wr_data = 16'd1;
			end
			WR_ZERO: begin
				wr_en   = ~flags.ptr_gt;
				wr_data = 16'd0;
			end
			WR_CNT: begin
				wr_en   = ~flags.ptr_gt & (rd_q != 16'd0);
				wr_data = cnt_inc;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign rd_en   = ctrl.rd_sel != RD_NONE;
	assign rd_addr = (ctrl.rd_sel == RD_QUERY) ? AW'(qv_q) : ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[ptr_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// A query outside 1..built limit, or before any build, is out of range.
	assign q_range = ~ready_q | (qv_q == 16'd0) | (32'(qv_q) > 32'(built_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b0;
			built_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (out_load && ctrl.out_op == OUT_BUILT) begin
				ready_q <= 1'b1;
				built_q <= lim_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			unique case (ctrl.out_op)
				OUT_BUILT: begin
					status_q <= ST_BUILT;
					rank_q   <= 16'd0;
				end
				OUT_QUERY: begin
					if (q_range) begin
						status_q <= ST_RANGE;
						rank_q   <= 16'd0;
					end else if (rd_q == 16'd0) begin
						status_q <= ST_NOT_FREE;
						rank_q   <= 16'd0;
					end else begin
						status_q <= ST_FREE;
						rank_q   <= rd_q;
					end
				end
				default: begin
					status_q <= status_q;
					rank_q   <= rank_q;
				end
			endcase
		end
	end

	// Only a cube-free answer carries a nonzero rank.
	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FREE |-> rank == 16'd0)
		else $error("nonzero rank on a result that is not cube free");

	a_rank_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FREE |-> rank != 16'd0)
		else $error("cube-free result with zero rank");

	// The memory is never written at entry zero or beyond the build limit.
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ptr_q != PW'(0) && !flags.ptr_gt)
		else $error("rank memory written outside the build range");

	// After a beat is taken, intake closes until the sequencer returns.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// The built flag rises together with a build-done result.
	a_built: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> out_valid && status == ST_BUILT)
		else $error("table marked built without a build-done result");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for cube_free_position_table: a directed table, then random
// phases of limit writes, builds and queries, each result checked against a local sieve.
// Depends on cfpt_pkg and the cube_free_position_table RTL.
module testbench;
	import cfpt_pkg::*;

	// Operation codes of the input beat.
	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Whether a directed row carries its own expected result or asks the sieve.
	localparam bit KNOWN   = 1'b1;
	localparam bit PREDICT = 1'b0;

	// The random part stops once about this many input beats have been accepted.
	localparam int ITEM_TARGET = 1100;
	// Cycles to watch for stray results once nothing is outstanding.
	localparam int TAIL_CYCLES = 40;

	typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [15:0] value;
		bit          typed;
		logic [1:0]  st;
		logic [15:0] rk;
	} stim_row_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] rk;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = OP_QUERY;
	logic [15:0] query_value = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] rank;

	cube_free_position_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.query_value(query_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.rank       (rank)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Local copy of the block's state. The rank table mirrors the block's memory: zero
	// marks a value that is not cube free, anything else is the value's position.
	bit [15:0] rank_of [0:65535];
	bit        table_built = 1'b0;
	bit [15:0] cover_limit = 16'd0;
	bit [15:0] limit_reg = 16'hFFFF;

	// Results still owed by the block, oldest first.
	answer_t pending_answers [$];

	int  mismatches = 0;
	int  random_beats = 0;
	// When set, neither side inserts gaps, so back-to-back traffic is exercised too.
	bit  quiet_stretch = 1'b0;
	int  ready_hold = 0;

	// Re-runs the sieve over 1..limit. Marking with every root, not only primes, gives
	// the same table, and a rebuild leaves entries above the new limit untouched.
	function automatic void sieve_build();
		int unsigned lim, v, k, cube, count;
		lim = limit_reg;
		for (v = 1; v <= lim; v++)
			rank_of[v] = 16'd1;
		for (k = 2; k * k * k <= lim; k++) begin
			cube = k * k * k;
			for (v = cube; v <= lim; v += cube)
				rank_of[v] = 16'd0;
		end
		count = 0;
		for (v = 1; v <= lim; v++) begin
			if (rank_of[v] != 16'd0) begin
				count++;
				rank_of[v] = count[15:0];
			end
		end
		cover_limit = lim[15:0];
		table_built = 1'b1;
	endfunction

	// Works out the result of one accepted beat and updates the local state.
	function automatic answer_t sieve_answer(input logic op, input logic [15:0] q);
		answer_t a;
		a.rk = 16'd0;
		if (op == OP_BUILD) begin
			sieve_build();
			a.st = ST_BUILT;
		end else if (!table_built || q == 16'd0 || q > cover_limit) begin
			a.st = ST_RANGE;
		end else if (rank_of[q] == 16'd0) begin
			a.st = ST_NOT_FREE;
		end else begin
			a.st = ST_FREE;
			a.rk = rank_of[q];
		end
		return a;
	endfunction

	// Appends one expected result behind those already owed.
	function automatic void owe_answer(input answer_t a);
		pending_answers.insert(pending_answers.size(), a);
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_stretch || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Query values lean on the interesting spots: the edges of the covered range,
	// multiples of small cubes, and now and then any 16-bit value at all.
	function automatic logic [15:0] pick_query();
		int unsigned lim, cube;
		lim = limit_reg;
		cube = $urandom_range(2, 12);
		cube = cube * cube * cube;
		case ($urandom_range(0, 11))
			0, 1: return 16'($urandom_range(0, 65535));
			2: return 16'd0;
			3: return limit_reg;
			4: return limit_reg + 16'd1;
			5, 6: return 16'(cube * $urandom_range(1, lim / cube + 1));
			default: return 16'($urandom_range(1, (lim == 0) ? 1 : lim));
		endcase
	endfunction

	// Most phases use small limits so that builds stay short; one phase may go wide.
	function automatic logic [15:0] choose_limit(input int phase_no);
		if (phase_no == 4)
			return 16'($urandom_range(1, 65535));
		case ($urandom_range(0, 15))
			0: return 16'd0;
			1: return 16'd1;
			2, 3: return 16'($urandom_range(2, 40));
			default: return 16'($urandom_range(41, 1500));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Presents one beat after a random gap and holds it until the block takes it. The
	// expected result is worked out at the edge of acceptance, so the local state always
	// matches what the block had when it took the beat. A typed row overrides the answer
	// but still updates the state.
	task automatic send_beat(input logic op, input logic [15:0] value, input bit typed,
			input logic [1:0] want_st, input logic [15:0] want_rk);
		int unsigned gap;
		answer_t a;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		query_value <= value;
		do @(posedge clk); while (!in_ready);
		a = sieve_answer(op, value);
		if (typed) begin
			a.st = want_st;
			a.rk = want_rk;
		end
		owe_answer(a);
	endtask

	// Drops valid and waits for every outstanding result. The queue is read at the
	// falling edge, after the checker has had its turn, and the task returns on a
	// rising edge so the caller can drive right away.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_answers.size() != 0);
		@(posedge clk);
	endtask

	// Writes the limit register once the block is idle. Every beat yields a result,
	// so an empty queue means the sequencer is back in its idle step.
	task automatic set_limit(input logic [15:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg = v;
	endtask

	// Result side: ready is high by default, and stalls of random length are started
	// at random, so they land on idle cycles, query reads and build passes alike.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else if (ready_hold != 0) begin
			out_ready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				ready_hold = pick_gap();
		end
	end

	// Every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: status %0d rank %0d",
					status, rank));
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (rank !== want.rk)
					report_mismatch($sformatf("rank %0d, expected %0d", rank, want.rk));
			end
		end
	end

	// Directed rows: kind, operation, value (limit on a limit row), typed flag, status,
	// rank. The first build uses the reset value of the limit, so it covers the whole
	// range once; later builds shrink the limit to show that stale entries stay hidden.
	stim_row_t directed_rows [0:25] = '{
		// Queries before any build are out of range.
		'{ROW_ITEM,  OP_QUERY, 16'd5,     KNOWN,   ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd0,     KNOWN,   ST_RANGE,    16'd0},
		// Full-range build at the reset limit.
		'{ROW_ITEM,  OP_BUILD, 16'h0000,  KNOWN,   ST_BUILT,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd1,     KNOWN,   ST_FREE,     16'd1},
		'{ROW_ITEM,  OP_QUERY, 16'd10,    KNOWN,   ST_FREE,     16'd9},
		'{ROW_ITEM,  OP_QUERY, 16'd8,     KNOWN,   ST_NOT_FREE, 16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd27,    KNOWN,   ST_NOT_FREE, 16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'h8000,  KNOWN,   ST_NOT_FREE, 16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'hFFFF,  PREDICT, ST_FREE,     16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'hFFFE,  PREDICT, ST_FREE,     16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd0,     KNOWN,   ST_RANGE,    16'd0},
		// Rebuild at the smallest nonzero limit.
		'{ROW_LIMIT, OP_BUILD, 16'd1,     PREDICT, ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_BUILD, 16'hFFFF,  KNOWN,   ST_BUILT,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd1,     KNOWN,   ST_FREE,     16'd1},
		'{ROW_ITEM,  OP_QUERY, 16'd2,     KNOWN,   ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'hFFFF,  KNOWN,   ST_RANGE,    16'd0},
		// A zero limit builds an empty table.
		'{ROW_LIMIT, OP_BUILD, 16'd0,     PREDICT, ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_BUILD, 16'h5A5A,  KNOWN,   ST_BUILT,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd1,     KNOWN,   ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd0,     KNOWN,   ST_RANGE,    16'd0},
		// A small table, probed just inside and just past its end.
		'{ROW_LIMIT, OP_BUILD, 16'd100,   PREDICT, ST_RANGE,    16'd0},
		'{ROW_ITEM,  OP_BUILD, 16'hA5A5,  KNOWN,   ST_BUILT,    16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd7,     KNOWN,   ST_FREE,     16'd7},
		'{ROW_ITEM,  OP_QUERY, 16'd64,    KNOWN,   ST_NOT_FREE, 16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd100,   PREDICT, ST_FREE,     16'd0},
		'{ROW_ITEM,  OP_QUERY, 16'd101,   KNOWN,   ST_RANGE,    16'd0}
	};

	initial begin : stimulus
		int phase_no;
		int burst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT)
				set_limit(directed_rows[i].value);
			else
				send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].st, directed_rows[i].rk);
		end

		// Random phases: a fresh limit, a build, then a burst of queries with the odd
		// rebuild mixed in. Some phases run without any gaps on either side.
		phase_no = 0;
		while (random_beats < ITEM_TARGET) begin
			set_limit(choose_limit(phase_no));
			quiet_stretch = ($urandom_range(0, 4) == 0);
			send_beat(OP_BUILD, 16'($urandom), PREDICT, ST_BUILT, 16'd0);
			random_beats++;
			burst = $urandom_range(30, 90);
			repeat (burst) begin
				if ($urandom_range(0, 63) == 0)
					send_beat(OP_BUILD, 16'($urandom), PREDICT, ST_BUILT, 16'd0);
				else
					send_beat(OP_QUERY, pick_query(), PREDICT, ST_BUILT, 16'd0);
				random_beats++;
			end
			phase_no++;
		end
		quiet_stretch = 1'b0;

		// Let everything drain, then watch a little longer for stray results.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("cube_free_position_table test passed");
		else
			$display("cube_free_position_table test failed");
		$finish;
	end

	// Watchdog. A full-range build is the longest item; the run holds at most a few of those
	// plus small builds and gaps, so the timeout leaves ample margin.
	initial begin
		#10_000_000;
		$display("cube_free_position_table test failed");
		$finish;
	end

endmodule
